// ===== design/trdh_pkg.sv =====
`default_nettype none

package trdh_pkg;

  localparam int TABLE_ENTRIES = 5;
  localparam int CFG_ADDR_W    = 5;

  localparam logic [2:0] ST_DISPATCHED = 3'd0;
  localparam logic [2:0] ST_ACCEPTED   = 3'd1;
  localparam logic [2:0] ST_SHORT      = 3'd2;
  localparam logic [2:0] ST_PAYLOAD    = 3'd3;
  localparam logic [2:0] ST_COUNTED    = 3'd4;

  localparam logic [1:0] SEL_COUNTED = 2'd0;
  localparam logic [1:0] SEL_PLAIN   = 2'd1;
  localparam logic [1:0] SEL_STAMP16 = 2'd2;
  localparam logic [1:0] SEL_STAMP32 = 2'd3;

  localparam logic [2:0] REG_ENDIAN  = 3'd0;
  localparam logic [2:0] REG_DOUBLED = 3'd1;
  localparam logic [2:0] REG_COUNTED = 3'd2;
  localparam logic [2:0] REG_ENTRY0  = 3'd3;

  localparam logic [5:0] STAMP16_BITS   = 6'd16;
  localparam logic [5:0] STAMP32_BITS   = 6'd32;
  localparam logic [6:0] ELEM_BYTE_BITS = 7'd8;

  localparam logic [3:0] HDR_LEN_MIN = 4'd4;
  localparam logic [3:0] HDR_LEN_MID = 4'd6;
  localparam logic [3:0] HDR_LEN_MAX = 4'd8;

  typedef struct packed {
    logic       enable;
    logic [6:0] elem_width;
    logic [13:0] id;
  } entry_t;

  typedef struct packed {
    logic                            big_endian;
    logic                            doubled_id;
    logic                            counted_x0;
    entry_t [TABLE_ENTRIES-1:0]      entries;
  } cfg_t;

  typedef struct packed {
    logic        lt4;
    logic [1:0]  sel;
    logic [15:0] first_word;
    logic [31:0] stamp;
    logic [5:0]  stamp_width;
    logic [3:0]  hdr_len;
    logic [14:0] payload_size;
    logic [15:0] buffer_length;
  } dec_t;

  typedef struct packed {
    logic        early_done;
    logic [2:0]  early_status;
    logic [15:0] first_word;
    logic [31:0] stamp;
    logic [5:0]  stamp_width;
    logic [14:0] payload_size;
    logic [15:0] consumed;
    logic        hit;
    logic [2:0]  hit_idx;
    logic [6:0]  hit_width;
  } look_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] consumed_length;
    logic [13:0] record_id;
    logic [31:0] stamp_value;
    logic [5:0]  stamp_width;
    logic [14:0] payload_size;
    logic [2:0]  matched_entry;
    logic [6:0]  element_width;
  } result_t;

  function automatic logic [15:0] word16(input logic [63:0] hdr, input logic [2:0] k,
                                         input logic be);
    logic [2:0] k1;
    logic [7:0] a;
    logic [7:0] b;
    k1 = k + 3'd1;
    a  = hdr[{k, 3'b000} +: 8];
    b  = hdr[{k1, 3'b000} +: 8];
    return be ? {a, b} : {b, a};
  endfunction

  function automatic logic [31:0] word32(input logic [63:0] hdr, input logic [2:0] k,
                                         input logic be);
    logic [15:0] w_lo;
    logic [15:0] w_hi;
    w_lo = word16(hdr, k, be);
    w_hi = word16(hdr, k + 3'd2, be);
    return be ? {w_lo, w_hi} : {w_hi, w_lo};
  endfunction

endpackage

`default_nettype wire

// ===== design/trdh_if.sv =====
`default_nettype none

interface trdh_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] header_bytes;
  logic [15:0] buffer_length;

  modport source (output valid, output header_bytes, output buffer_length, input ready);
  modport sink   (input valid, input header_bytes, input buffer_length, output ready);
endinterface

interface trdh_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] consumed_length;
  logic [13:0] record_id;
  logic [31:0] stamp_value;
  logic [5:0]  stamp_width;
  logic [14:0] payload_size;
  logic [2:0]  matched_entry;
  logic [6:0]  element_width;

  modport source (output valid, output status, output consumed_length, output record_id,
                  output stamp_value, output stamp_width, output payload_size,
                  output matched_entry, output element_width, input ready);
  modport sink   (input valid, input status, input consumed_length, input record_id,
                  input stamp_value, input stamp_width, input payload_size,
                  input matched_entry, input element_width, output ready);
endinterface

`default_nettype wire

// ===== design/trdh_decode.sv =====
`default_nettype none

module trdh_decode (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire trdh_pkg::cfg_t cfg,
  input  wire logic          up_valid,
  output logic               up_ready,
  input  wire logic [63:0]   header_bytes,
  input  wire logic [15:0]   buffer_length,
  output logic               dn_valid,
  input  wire logic          dn_ready,
  output trdh_pkg::dec_t     dn_data
);
  import trdh_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  dec_t        data_r;
  dec_t        data_nxt;
  logic [15:0] w0;
  logic [15:0] len_word;

  always_comb begin
    w0       = word16(header_bytes, 3'd0, cfg.big_endian);
    data_nxt = '0;
    len_word = word16(header_bytes, 3'd2, cfg.big_endian);
    data_nxt.lt4           = buffer_length < 16'd4;
    data_nxt.sel           = w0[15:14];
    data_nxt.first_word    = w0;
    data_nxt.buffer_length = buffer_length;
    data_nxt.hdr_len       = HDR_LEN_MIN;
    unique case (w0[15:14])
      SEL_STAMP16: begin
        data_nxt.stamp_width = STAMP16_BITS;
        if (cfg.doubled_id) begin
          data_nxt.stamp   = {16'd0, word16(header_bytes, 3'd4, cfg.big_endian)};
          len_word         = word16(header_bytes, 3'd6, cfg.big_endian);
          data_nxt.hdr_len = HDR_LEN_MAX;
        end else begin
          data_nxt.stamp   = {16'd0, word16(header_bytes, 3'd2, cfg.big_endian)};
          len_word         = word16(header_bytes, 3'd4, cfg.big_endian);
          data_nxt.hdr_len = HDR_LEN_MID;
        end
      end
      SEL_STAMP32: begin
        data_nxt.stamp_width = STAMP32_BITS;
        data_nxt.stamp       = word32(header_bytes, 3'd2, cfg.big_endian);
        len_word             = word16(header_bytes, 3'd6, cfg.big_endian);
        data_nxt.hdr_len     = HDR_LEN_MAX;
      end
      SEL_PLAIN, SEL_COUNTED: begin
        data_nxt.stamp_width = '0;
      end
      default: begin
        data_nxt.stamp_width = '0;
      end
    endcase
    data_nxt.payload_size = len_word[15] ? len_word[14:0] : {7'd0, len_word[15:8]};
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== design/trdh_lookup.sv =====
`default_nettype none

module trdh_lookup (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire trdh_pkg::cfg_t cfg,
  input  wire logic           up_valid,
  output logic                up_ready,
  input  wire trdh_pkg::dec_t up_data,
  output logic                dn_valid,
  input  wire logic           dn_ready,
  output trdh_pkg::look_t     dn_data
);
  import trdh_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  look_t       data_r;
  look_t       data_nxt;
  logic [15:0] need;
  logic        found;
  entry_t      found_entry;
  logic [2:0]  found_idx;

  always_comb begin
    need        = {12'd0, up_data.hdr_len} + {1'b0, up_data.payload_size};
    found       = 1'b0;
    found_entry = '0;
    found_idx   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (cfg.entries[i].id == up_data.first_word[13:0]) begin
        found       = 1'b1;
        found_entry = cfg.entries[i];
        found_idx   = 3'(i);
      end
    end

    data_nxt              = '0;
    data_nxt.first_word   = up_data.first_word;
    data_nxt.stamp        = up_data.stamp;
    data_nxt.stamp_width  = up_data.stamp_width;
    data_nxt.payload_size = up_data.payload_size;
    data_nxt.consumed     = need;
    data_nxt.hit          = found && found_entry.enable;
    data_nxt.hit_idx      = found_idx;
    data_nxt.hit_width    = found_entry.elem_width;

    priority if (up_data.lt4) begin
      data_nxt.early_done   = 1'b1;
      data_nxt.early_status = ST_SHORT;
    end else if (up_data.sel == SEL_COUNTED) begin
      data_nxt.early_done   = 1'b1;
      data_nxt.early_status = cfg.counted_x0 ? ST_COUNTED : ST_PAYLOAD;
    end else if (up_data.buffer_length < need) begin
      data_nxt.early_done   = 1'b1;
      data_nxt.early_status = ST_SHORT;
    end else begin
      data_nxt.early_done   = 1'b0;
      data_nxt.early_status = ST_ACCEPTED;
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== design/trdh_resolve.sv =====
`default_nettype none

module trdh_resolve (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire trdh_pkg::look_t up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output trdh_pkg::result_t    dn_data
);
  import trdh_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  result_t    data_r;
  result_t    data_nxt;
  logic [3:0] elem_mask;
  logic       elem_bad;

  always_comb begin
    elem_mask = up_data.hit_width[6:3] - 4'd1;
    elem_bad  = (up_data.payload_size != '0) &&
                ((up_data.hit_width == '0) ||
                 ((up_data.hit_width > ELEM_BYTE_BITS) &&
                  ((up_data.payload_size[3:0] & elem_mask) != '0)));
    data_nxt = '0;
    priority if (up_data.early_done) begin
      data_nxt.status = up_data.early_status;
      if (up_data.early_status == ST_COUNTED) begin
        data_nxt.consumed_length = up_data.first_word;
      end
    end else if (up_data.hit && elem_bad) begin
      data_nxt.status = ST_PAYLOAD;
    end else begin
      data_nxt.status          = up_data.hit ? ST_DISPATCHED : ST_ACCEPTED;
      data_nxt.consumed_length = up_data.consumed;
      data_nxt.record_id       = up_data.first_word[13:0];
      data_nxt.stamp_value     = up_data.stamp;
      data_nxt.stamp_width     = up_data.stamp_width;
      data_nxt.payload_size    = up_data.payload_size;
      if (up_data.hit) begin
        data_nxt.matched_entry = up_data.hit_idx;
        data_nxt.element_width = up_data.hit_width;
      end
    end
  end

  assign up_ready  = !valid_r || dn_ready;
  assign valid_nxt = up_ready ? up_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

// ===== design/trace_record_header_dispatch_unit.sv =====
// Channel   Direction  Transfer when         Contents
// in_ch     sink       valid && ready        header_bytes, buffer_length
// out_ch    source     valid && ready        status, lengths, id, stamp, match
// cfg_*     APB slave  psel/penable/pwrite   eight 32-bit registers at 4*i
//
// Every record header is registered in decode, lookup and resolve before its result is valid.
// The three stages (field decode, length check with handler compare, element check)
// each hold one record, so one header is accepted per cycle until a stall on out_ch fills them.
// Reset clears the pipeline valid bits and all configuration registers.
// A stall on out_ch holds each stage, and in_ch.ready drops only when all stages are full.
`default_nettype none

module trace_record_header_dispatch_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  trdh_in_if.sink                                 in_ch,
  trdh_out_if.source                              out_ch,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [trdh_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [31:0]                        cfg_pwdata,
  output logic [31:0]                             cfg_prdata,
  output logic                                    cfg_pready
);
  import trdh_pkg::*;

  logic                       big_endian_r;
  logic                       doubled_id_r;
  logic                       counted_x0_r;
  entry_t [TABLE_ENTRIES-1:0] entries_r;
  cfg_t                       cfg;
  logic                       cfg_wr;
  logic [2:0]                 reg_idx;
  logic [2:0]                 entry_idx;

  logic    dec_valid;
  logic    dec_ready;
  dec_t    dec_data;
  logic    look_valid;
  logic    look_ready;
  look_t   look_data;
  result_t res_data;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign entry_idx  = reg_idx - REG_ENTRY0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      big_endian_r <= 1'b0;
      doubled_id_r <= 1'b0;
      counted_x0_r <= 1'b0;
      entries_r    <= '0;
    end else if (cfg_wr) begin
      priority if (reg_idx == REG_ENDIAN) begin
        big_endian_r <= cfg_pwdata[0];
      end else if (reg_idx == REG_DOUBLED) begin
        doubled_id_r <= cfg_pwdata[0];
      end else if (reg_idx == REG_COUNTED) begin
        counted_x0_r <= cfg_pwdata[0];
      end else begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (entry_idx == 3'(i)) begin
            entries_r[i] <= entry_t'(cfg_pwdata[21:0]);
          end
        end
      end
    end
  end

  always_comb begin
    cfg_prdata = '0;
    priority if (reg_idx == REG_ENDIAN) begin
      cfg_prdata = {31'd0, big_endian_r};
    end else if (reg_idx == REG_DOUBLED) begin
      cfg_prdata = {31'd0, doubled_id_r};
    end else if (reg_idx == REG_COUNTED) begin
      cfg_prdata = {31'd0, counted_x0_r};
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (entry_idx == 3'(i)) begin
          cfg_prdata = {10'd0, entries_r[i]};
        end
      end
    end
  end

  assign cfg.big_endian = big_endian_r;
  assign cfg.doubled_id = doubled_id_r;
  assign cfg.counted_x0 = counted_x0_r;
  assign cfg.entries    = entries_r;

  trdh_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .up_valid      (in_ch.valid),
    .up_ready      (in_ch.ready),
    .header_bytes  (in_ch.header_bytes),
    .buffer_length (in_ch.buffer_length),
    .dn_valid      (dec_valid),
    .dn_ready      (dec_ready),
    .dn_data       (dec_data)
  );

  trdh_lookup u_lookup (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (dec_valid),
    .up_ready (dec_ready),
    .up_data  (dec_data),
    .dn_valid (look_valid),
    .dn_ready (look_ready),
    .dn_data  (look_data)
  );

  trdh_resolve u_resolve (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (look_valid),
    .up_ready (look_ready),
    .up_data  (look_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (res_data)
  );

  assign out_ch.status          = res_data.status;
  assign out_ch.consumed_length = res_data.consumed_length;
  assign out_ch.record_id       = res_data.record_id;
  assign out_ch.stamp_value     = res_data.stamp_value;
  assign out_ch.stamp_width     = res_data.stamp_width;
  assign out_ch.payload_size    = res_data.payload_size;
  assign out_ch.matched_entry   = res_data.matched_entry;
  assign out_ch.element_width   = res_data.element_width;

  a_full_only_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_ch.valid && !out_ch.ready && look_valid && dec_valid))
    else $error("input stalled while the pipeline can still advance");

  a_dispatch_whole_elements: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_DISPATCHED) |->
      (out_ch.element_width != '0 || out_ch.payload_size == '0))
    else $error("dispatched record with zero element width and a payload");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status == ST_SHORT || out_ch.status == ST_PAYLOAD)) |->
      (out_ch.consumed_length == '0 && out_ch.record_id == '0 &&
       out_ch.stamp_width == '0 && out_ch.matched_entry == '0))
    else $error("error result carries decoded fields");

  a_match_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_DISPATCHED) |->
      (out_ch.matched_entry < 3'(TABLE_ENTRIES) &&
       out_ch.consumed_length >= {10'd0, out_ch.stamp_width} / 16'd8 + 16'd4))
    else $error("dispatched result with an impossible entry or length");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trdh_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PHASE_ITEMS  = 330;
  localparam int PHASE_COUNT  = 6;
  localparam int PRINT_LIMIT  = 40;

  typedef struct {
    logic [63:0] hdr;
    logic [15:0] blen;
  } header_item_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]           cfg_pwdata  = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  trdh_in_if  in_ch ();
  trdh_out_if out_ch ();

  trace_record_header_dispatch_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Local copy of the register file, kept in step with every write.
  logic   cfg_big_endian = 1'b0;
  logic   cfg_doubled    = 1'b0;
  logic   cfg_counted    = 1'b0;
  entry_t entry_tab  [TABLE_ENTRIES];
  entry_t table_plan [TABLE_ENTRIES];

  header_item_t pending_records[$];
  result_t      awaited_decodes[$];

  int send_idle_pct = 7;
  int recv_idle_pct = 76;
  int error_count   = 0;
  int results_seen  = 0;
  int records_sent  = 0;
  int stall_cycles  = 0;
  int settings_used = 0;
  int quiet_cycles  = 0;
  int hold_left     = 0;
  int holds_wanted  = 0;
  int holds_done    = 0;
  int status_hits [5] = '{default: 0};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [15:0] hdr_word16(input logic [63:0] hdr, input int unsigned k);
    logic [7:0] a;
    logic [7:0] b;
    a = hdr[(k % 8) * 8 +: 8];
    b = hdr[((k + 1) % 8) * 8 +: 8];
    return cfg_big_endian ? {a, b} : {b, a};
  endfunction

  function automatic logic [31:0] hdr_word32(input logic [63:0] hdr, input int unsigned k);
    logic [15:0] first;
    logic [15:0] second;
    first  = hdr_word16(hdr, k);
    second = hdr_word16(hdr, k + 2);
    return cfg_big_endian ? {first, second} : {second, first};
  endfunction

  function automatic result_t decode_header(input logic [63:0] hdr, input logic [15:0] blen);
    result_t     r;
    logic [15:0] w;
    logic [13:0] id;
    logic [1:0]  sel;
    logic [31:0] stamp;
    logic [5:0]  sw;
    logic [14:0] psize;
    logic [6:0]  bw;
    int unsigned off;
    int          found;
    int          i;
    r     = '0;
    stamp = '0;
    sw    = '0;
    off   = 2;
    found = -1;
    r.status = ST_SHORT;
    if (blen < 16'd4) return r;
    w   = hdr_word16(hdr, 0);
    id  = w[13:0];
    sel = w[15:14];
    if (sel == SEL_COUNTED) begin
      if (cfg_counted) begin
        r.status          = ST_COUNTED;
        r.consumed_length = w;
      end else begin
        r.status = ST_PAYLOAD;
      end
      return r;
    end
    if (sel == SEL_STAMP16) begin
      sw = STAMP16_BITS;
      if (cfg_doubled) off += 2;
      if (blen < off + 2) return r;
      stamp = {16'd0, hdr_word16(hdr, off)};
      off += 2;
    end else if (sel == SEL_STAMP32) begin
      sw = STAMP32_BITS;
      if (blen < off + 4) return r;
      stamp = hdr_word32(hdr, off);
      off += 4;
    end
    if (blen < off + 2) return r;
    w = hdr_word16(hdr, off);
    off += 2;
    psize = w[15] ? w[14:0] : {7'd0, w[15:8]};
    if (blen < off + psize) return r;
    for (i = 0; i < TABLE_ENTRIES; i++)
      if (found < 0 && entry_tab[i].id == id) found = i;
    r.status = ST_ACCEPTED;
    if (found >= 0 && entry_tab[found].enable) begin
      bw = entry_tab[found].elem_width;
      if (psize != 0 && (bw == 0 ||
          (bw > ELEM_BYTE_BITS && (psize & (15'(bw >> 3) - 15'd1)) != 0))) begin
        r        = '0;
        r.status = ST_PAYLOAD;
        return r;
      end
      r.status        = ST_DISPATCHED;
      r.matched_entry = found[2:0];
      r.element_width = bw;
    end
    r.consumed_length = 16'(off + psize);
    r.record_id       = id;
    r.stamp_value     = stamp;
    r.stamp_width     = sw;
    r.payload_size    = psize;
    return r;
  endfunction

  function automatic void put_word16(inout logic [63:0] hdr, input int unsigned k,
                                     input logic [15:0] w);
    if (cfg_big_endian) begin
      hdr[k * 8 +: 8]       = w[15:8];
      hdr[(k + 1) * 8 +: 8] = w[7:0];
    end else begin
      hdr[k * 8 +: 8]       = w[7:0];
      hdr[(k + 1) * 8 +: 8] = w[15:8];
    end
  endfunction

  function automatic int unsigned length_offset(input logic [1:0] sel);
    if (sel == SEL_STAMP16) return cfg_doubled ? 6 : 4;
    if (sel == SEL_STAMP32) return 6;
    return 2;
  endfunction

  // Short form keeps the size in bits 15:8 with bit 15 clear, so it holds at most 127.
  function automatic logic [15:0] len_word(input logic [14:0] psize, input logic long_form);
    return long_form ? {1'b1, psize} : {psize[7:0], 8'($urandom)};
  endfunction

  function automatic logic [63:0] make_header(input logic [1:0] sel, input logic [13:0] id,
                                              input logic [31:0] stamp,
                                              input logic [15:0] lw);
    logic [63:0] hdr;
    hdr = {$urandom, $urandom};
    put_word16(hdr, 0, {sel, id});
    if (sel == SEL_STAMP16) begin
      put_word16(hdr, length_offset(sel) - 2, stamp[15:0]);
    end else if (sel == SEL_STAMP32) begin
      put_word16(hdr, 2, cfg_big_endian ? stamp[31:16] : stamp[15:0]);
      put_word16(hdr, 4, cfg_big_endian ? stamp[15:0] : stamp[31:16]);
    end
    put_word16(hdr, length_offset(sel), lw);
    return hdr;
  endfunction

  function automatic header_item_t make_record();
    header_item_t it;
    logic [1:0]   sel;
    logic [13:0]  id;
    logic [14:0]  psize;
    logic [6:0]   bw;
    int unsigned  pick;
    int unsigned  need;
    int unsigned  roomy;
    if ($urandom_range(0, 99) < 12) begin
      it.hdr  = {$urandom, $urandom};
      it.blen = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 12));
      return it;
    end
    sel  = 2'($urandom);
    pick = $urandom_range(0, TABLE_ENTRIES - 1);
    id   = ($urandom_range(0, 3) != 0) ? entry_tab[pick].id : 14'($urandom);
    bw   = entry_tab[pick].elem_width;
    case ($urandom_range(0, 9))
      0:       psize = 15'($urandom);
      1:       psize = '0;
      default: psize = 15'($urandom_range(0, 48));
    endcase
    if ($urandom_range(0, 1) != 0 && bw > ELEM_BYTE_BITS)
      psize = psize & ~(15'(bw >> 3) - 15'd1);
    it.hdr = make_header(sel, id, $urandom,
                         len_word(psize, psize > 127 || $urandom_range(0, 1) != 0));
    need  = length_offset(sel) + 2 + psize;
    roomy = need + $urandom_range(0, 16);
    case ($urandom_range(0, 19))
      0, 1, 2: it.blen = 16'(need - $urandom_range(1, 4));
      3:       it.blen = 16'hFFFF;
      4:       it.blen = 16'($urandom);
      default: it.blen = (roomy > 65535) ? 16'hFFFF : 16'(roomy);
    endcase
    return it;
  endfunction

  task automatic push_record(input logic [63:0] hdr, input logic [15:0] blen);
    header_item_t it;
    it.hdr  = hdr;
    it.blen = blen;
    pending_records.push_back(it);
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_ENDIAN:  cfg_big_endian = val[0];
      REG_DOUBLED: cfg_doubled    = val[0];
      REG_COUNTED: cfg_counted    = val[0];
      default:     entry_tab[idx - REG_ENTRY0] = val[21:0];
    endcase
  endtask

  task automatic program_config(input logic be, input logic dbl, input logic cnt);
    int i;
    set_register(REG_ENDIAN, {31'($urandom), be});
    set_register(REG_DOUBLED, {31'($urandom), dbl});
    set_register(REG_COUNTED, {31'($urandom), cnt});
    for (i = 0; i < TABLE_ENTRIES; i++)
      set_register(REG_ENTRY0 + 3'(i), {10'($urandom), table_plan[i]});
    settings_used++;
  endtask

  function automatic entry_t random_entry();
    entry_t e;
    e.id     = 14'($urandom);
    e.enable = ($urandom_range(0, 4) != 0);
    case ($urandom_range(0, 6))
      0:       e.elem_width = 7'd0;
      1:       e.elem_width = 7'd8;
      2:       e.elem_width = 7'd16;
      3:       e.elem_width = 7'd32;
      4:       e.elem_width = 7'd64;
      5:       e.elem_width = 7'd127;
      default: e.elem_width = 7'($urandom);
    endcase
    return e;
  endfunction

  // Sampled away from the rising edge so that the driver has settled.
  task automatic wait_idle();
    @(negedge clk);
    while (pending_records.size() != 0 || in_ch.valid || awaited_decodes.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (error_count < PRINT_LIMIT)
      $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
               results_seen, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : drive_records
    header_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        awaited_decodes.push_back(decode_header(in_ch.header_bytes, in_ch.buffer_length));
        records_sent++;
      end
      if (in_ch.valid && !in_ch.ready) stall_cycles++;
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_records.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_records.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.header_bytes  <= nxt.hdr;
          in_ch.buffer_length <= nxt.blen;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.status          = out_ch.status;
        got.consumed_length = out_ch.consumed_length;
        got.record_id       = out_ch.record_id;
        got.stamp_value     = out_ch.stamp_value;
        got.stamp_width     = out_ch.stamp_width;
        got.payload_size    = out_ch.payload_size;
        got.matched_entry   = out_ch.matched_entry;
        got.element_width   = out_ch.element_width;
        if (awaited_decodes.size() == 0) begin
          report_mismatch("result with none outstanding, status", got.status, 0);
        end else begin
          want = awaited_decodes.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
          if (got.consumed_length !== want.consumed_length)
            report_mismatch("consumed_length", got.consumed_length, want.consumed_length);
          if (got.record_id !== want.record_id)
            report_mismatch("record_id", got.record_id, want.record_id);
          if (got.stamp_value !== want.stamp_value)
            report_mismatch("stamp_value", got.stamp_value, want.stamp_value);
          if (got.stamp_width !== want.stamp_width)
            report_mismatch("stamp_width", got.stamp_width, want.stamp_width);
          if (got.payload_size !== want.payload_size)
            report_mismatch("payload_size", got.payload_size, want.payload_size);
          if (got.matched_entry !== want.matched_entry)
            report_mismatch("matched_entry", got.matched_entry, want.matched_entry);
          if (got.element_width !== want.element_width)
            report_mismatch("element_width", got.element_width, want.element_width);
          if (want.status <= ST_COUNTED) status_hits[want.status]++;
        end
        results_seen++;
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_wanted != holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d cycles without a transfer", quiet_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int p;
    int n;
    int i;
    in_ch.valid         = 1'b0;
    in_ch.header_bytes  = '0;
    in_ch.buffer_length = '0;
    out_ch.ready        = 1'b0;
    for (i = 0; i < TABLE_ENTRIES; i++) entry_tab[i] = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: no counted packets, every entry holds id 0 disabled.
    push_record(make_header(SEL_COUNTED, 14'h0ABC, 32'd0, len_word(15'd5, 1'b1)), 16'd100);
    push_record(make_header(SEL_PLAIN, 14'h0000, 32'd0, len_word(15'd3, 1'b0)), 16'd7);
    push_record(make_header(SEL_PLAIN, 14'h0007, 32'd0, len_word(15'd0, 1'b1)), 16'd4);
    wait_idle();

    table_plan[0] = '{enable: 1'b1, elem_width: 7'd8,  id: 14'h0005};
    table_plan[1] = '{enable: 1'b1, elem_width: 7'd32, id: 14'h3FFF};
    table_plan[2] = '{enable: 1'b1, elem_width: 7'd0,  id: 14'h0100};
    table_plan[3] = '{enable: 1'b1, elem_width: 7'd16, id: 14'h0005};
    table_plan[4] = '{enable: 1'b0, elem_width: 7'd16, id: 14'h0200};
    program_config(1'b0, 1'b1, 1'b1);
    push_record(64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
    push_record(make_header(SEL_PLAIN, 14'h0005, 32'd0, len_word(15'd3, 1'b0)), 16'd3);
    push_record(make_header(SEL_COUNTED, 14'h3FFF, 32'd0, len_word(15'd0, 1'b0)), 16'd20);
    push_record(make_header(SEL_PLAIN, 14'h0005, 32'd0, len_word(15'd3, 1'b0)), 16'd7);
    push_record(make_header(SEL_PLAIN, 14'h0005, 32'd0, len_word(15'd3, 1'b0)), 16'd6);
    push_record(make_header(SEL_STAMP16, 14'h3FFF, 32'hBEEF, len_word(15'd4, 1'b1)), 16'd12);
    push_record(make_header(SEL_STAMP16, 14'h3FFF, 32'hBEEF, len_word(15'd6, 1'b1)), 16'd14);
    push_record(make_header(SEL_STAMP32, 14'h0100, 32'hFFFF_FFFF, len_word(15'd0, 1'b1)),
                16'd8);
    push_record(make_header(SEL_STAMP32, 14'h0100, 32'h1234_5678, len_word(15'd1, 1'b0)),
                16'd9);
    push_record(make_header(SEL_STAMP16, 14'h0005, 32'h0000, len_word(15'd0, 1'b0)), 16'd5);
    push_record(make_header(SEL_STAMP32, 14'h0005, 32'h0000, len_word(15'd0, 1'b0)), 16'd7);
    push_record(make_header(SEL_PLAIN, 14'h0200, 32'd0, len_word(15'd2, 1'b0)), 16'd6);
    push_record(make_header(SEL_PLAIN, 14'h1234, 32'd0, len_word(15'd2, 1'b1)), 16'd40);
    push_record(make_header(SEL_PLAIN, 14'h1234, 32'd0, len_word(15'h7FFF, 1'b1)), 16'hFFFF);
    push_record(make_header(SEL_STAMP32, 14'h1234, 32'h0, len_word(15'h7FFF, 1'b1)), 16'hFFFF);
    push_record(make_header(SEL_PLAIN, 14'h1234, 32'd0, len_word(15'd127, 1'b0)), 16'd131);
    push_record(64'h0, 16'hFFFF);
    push_record(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    push_record(make_header(SEL_PLAIN, 14'h0005, 32'd0, len_word(15'd5, 1'b0)), 16'd9);
    wait_idle();

    for (p = 0; p < PHASE_COUNT; p++) begin
      send_idle_pct = (p < 2) ? 7 : (p < 4) ? 76 : 0;
      recv_idle_pct = (p < 2) ? 76 : (p < 4) ? 7 : 0;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        table_plan[i] = random_entry();
        if (i > 0 && $urandom_range(0, 3) == 0) table_plan[i].id = table_plan[i - 1].id;
      end
      if (p == 0) table_plan[0] = '0;
      if (p == 1) table_plan[TABLE_ENTRIES - 1] = '1;
      if (p == 0)
        program_config(1'b0, 1'b0, 1'b0);
      else if (p == 1)
        program_config(1'b1, 1'b1, 1'b1);
      else
        program_config(1'($urandom), 1'($urandom), 1'($urandom));
      if (p == 4) holds_wanted <= holds_wanted + 1;
      for (n = 0; n < PHASE_ITEMS; n++) pending_records.push_back(make_record());
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (awaited_decodes.size() != 0)
      report_mismatch("results never delivered, count", awaited_decodes.size(), 0);
    $display("Decoded %0d record headers under %0d register settings; input held off %0d cycles.",
             records_sent, settings_used, stall_cycles);
    $display("Status mix: dispatched %0d, accepted %0d, short %0d, payload error %0d, counted %0d.",
             status_hits[ST_DISPATCHED], status_hits[ST_ACCEPTED], status_hits[ST_SHORT],
             status_hits[ST_PAYLOAD], status_hits[ST_COUNTED]);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/trdh_pkg.sv
design/trdh_if.sv
design/trdh_decode.sv
design/trdh_lookup.sv
design/trdh_resolve.sv
design/trace_record_header_dispatch_unit.sv
tb/sv/tb.sv
